// File: hw/rtl/tssq_pkg.sv
// ----------------------------------------------------------------------------
// tssq_pkg
// Shared widths, codes and reset values for the supply rail switch sequencer.
// ----------------------------------------------------------------------------
package tssq_pkg;

    localparam int ACTION_W   = 2;
    localparam int VOLTAGE_W  = 8;
    localparam int DUTY_W     = 16;
    localparam int TICK_W     = 16;
    localparam int DELAY_W    = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 48;

    localparam logic [ACTION_W-1:0] ACT_TICK    = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_VOLTAGE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_DUTY    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_CONTROL_PERIOD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_STEPS     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_OFF_DELAY = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_OFF_DELAY  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PWM_OFF_DUTY   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CODE_FULL_RAIL = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CODE_BAND_LOW  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_CODE_BAND_HIGH = 3'd7;

    localparam logic [TICK_W-1:0]    RST_CONTROL_PERIOD = 16'd100;
    localparam logic [TICK_W-1:0]    RST_HOLD_STEPS     = 16'd600;
    localparam logic [DELAY_W-1:0]   RST_HIGH_OFF_DELAY = 8'd1;
    localparam logic [DELAY_W-1:0]   RST_LOW_OFF_DELAY  = 8'd1;
    localparam logic [DUTY_W-1:0]    RST_PWM_OFF_DUTY   = 16'd0;
    localparam logic [VOLTAGE_W-1:0] RST_CODE_FULL_RAIL = 8'd24;
    localparam logic [VOLTAGE_W-1:0] RST_CODE_BAND_LOW  = 8'd5;
    localparam logic [VOLTAGE_W-1:0] RST_CODE_BAND_HIGH = 8'd12;

    localparam int STEP_BIT = 42;

endpackage

// File: hw/rtl/tem_supply_rail_switch_sequencer_unit.sv
// ----------------------------------------------------------------------------
// tem_supply_rail_switch_sequencer_unit
// Tick driven control of the 24 V and PWM regulated rails of a thermoelectric
// module, with break-before-make port switching and a duty hold on changes.
// ----------------------------------------------------------------------------
// A result appears in the cycle after its input transaction is accepted.
// Throughput: one transaction per cycle unless the result side stalls;
// the state update and the result packing sit before a single output register.
// Reset: aresetn is synchronous and active low; it clears all state but the
// output data register, turns both ports off and loads the register defaults.
module tem_supply_rail_switch_sequencer_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // voltage_value [7:0], duty_value [23:8]
    input  logic [tssq_pkg::IN_DATA_W-1:0]  s_tdata,
    // action [1:0]
    input  logic [tssq_pkg::ACTION_W-1:0]   s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // high_rail_on [0], low_rail_on [1], pwm_compare [17:2],
    // voltage_readback [25:18], duty_readback [41:26], step_done [42]
    output logic [tssq_pkg::OUT_DATA_W-1:0] m_tdata,
    input  logic                            cfg_we,
    input  logic [tssq_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tssq_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import tssq_pkg::*;

    logic [TICK_W-1:0]    control_period_reg;
    logic [TICK_W-1:0]    hold_steps_reg;
    logic [DELAY_W-1:0]   high_off_delay_reg;
    logic [DELAY_W-1:0]   low_off_delay_reg;
    logic [DUTY_W-1:0]    pwm_off_duty_reg;
    logic [VOLTAGE_W-1:0] code_full_rail_reg;
    logic [VOLTAGE_W-1:0] code_band_low_reg;
    logic [VOLTAGE_W-1:0] code_band_high_reg;

    logic [TICK_W-1:0]    tick_count_reg,    tick_count_next;
    logic [VOLTAGE_W-1:0] voltage_req_reg,   voltage_req_next;
    logic [DUTY_W-1:0]    duty_req_reg,      duty_req_next;
    logic [VOLTAGE_W-1:0] voltage_acc_reg,   voltage_acc_next;
    logic [DUTY_W-1:0]    duty_acc_reg,      duty_acc_next;
    logic [TICK_W-1:0]    hold_count_reg,    hold_count_next;
    logic [DELAY_W-1:0]   high_off_cnt_reg,  high_off_cnt_next;
    logic [DELAY_W-1:0]   low_off_cnt_reg,   low_off_cnt_next;
    logic                 high_port_reg,     high_port_next;
    logic                 low_port_reg,      low_port_next;
    logic [DUTY_W-1:0]    pwm_value_reg,     pwm_value_next;
    logic                 m_tvalid_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg,      m_tdata_next;

    logic                 s_accept;
    logic [ACTION_W-1:0]  s_action;
    logic [VOLTAGE_W-1:0] s_voltage;
    logic [DUTY_W-1:0]    s_duty;
    logic [TICK_W-1:0]    tick_inc;
    logic [DELAY_W-1:0]   high_off_dec;
    logic [DELAY_W-1:0]   low_off_dec;
    logic                 hold_active;
    logic [DUTY_W-1:0]    duty_now;
    logic                 step_run;

    assign s_tready  = !m_tvalid_reg || m_tready;
    assign s_accept  = s_tvalid && s_tready;
    assign s_action  = s_tuser;
    assign s_voltage = s_tdata[VOLTAGE_W-1:0];
    assign s_duty    = s_tdata[VOLTAGE_W+DUTY_W-1:VOLTAGE_W];

    assign tick_inc     = (tick_count_reg < control_period_reg) ?
                          tick_count_reg + TICK_W'(1) : tick_count_reg;
    assign high_off_dec = (high_off_cnt_reg != '0) ?
                          high_off_cnt_reg - DELAY_W'(1) : high_off_cnt_reg;
    assign low_off_dec  = (low_off_cnt_reg != '0) ?
                          low_off_cnt_reg - DELAY_W'(1) : low_off_cnt_reg;
    assign hold_active  = (voltage_req_reg != voltage_acc_reg) && (hold_count_reg != '0);
    assign duty_now     = hold_active ? duty_acc_reg : duty_req_reg;

    always_comb begin
        tick_count_next   = tick_count_reg;
        voltage_req_next  = voltage_req_reg;
        duty_req_next     = duty_req_reg;
        voltage_acc_next  = voltage_acc_reg;
        duty_acc_next     = duty_acc_reg;
        hold_count_next   = hold_count_reg;
        high_off_cnt_next = high_off_cnt_reg;
        low_off_cnt_next  = low_off_cnt_reg;
        high_port_next    = high_port_reg;
        low_port_next     = low_port_reg;
        pwm_value_next    = pwm_value_reg;
        step_run          = 1'b0;

        if (s_accept) begin
            unique case (s_action)
                ACT_TICK: begin
                    tick_count_next = tick_inc;
                    step_run        = (tick_inc >= control_period_reg);
                end
                ACT_VOLTAGE: begin
                    voltage_req_next = s_voltage;
                end
                ACT_DUTY: begin
                    duty_req_next = s_duty;
                end
                default: begin
                end
            endcase
        end

        if (step_run) begin
            tick_count_next   = '0;
            high_off_cnt_next = high_off_dec;
            low_off_cnt_next  = low_off_dec;
            if (hold_active) begin
                hold_count_next = hold_count_reg - TICK_W'(1);
            end else begin
                hold_count_next  = hold_steps_reg;
                voltage_acc_next = voltage_req_reg;
                duty_acc_next    = duty_req_reg;
            end
            if (voltage_req_reg == code_full_rail_reg) begin
                high_port_next = 1'b1;
                if (low_off_dec == '0) begin
                    low_port_next = 1'b0;
                end
                pwm_value_next    = pwm_off_duty_reg;
                high_off_cnt_next = high_off_delay_reg;
            end else if (voltage_req_reg >= code_band_low_reg &&
                         voltage_req_reg <= code_band_high_reg) begin
                low_port_next    = 1'b1;
                pwm_value_next   = duty_now;
                high_port_next   = (high_off_dec != '0);
                low_off_cnt_next = low_off_delay_reg;
            end else begin
                high_port_next   = 1'b0;
                low_port_next    = 1'b0;
                pwm_value_next   = pwm_off_duty_reg;
                voltage_req_next = '0;
            end
        end

        m_tdata_next = {5'b0, step_run, duty_req_next, voltage_req_next,
                        pwm_value_next, low_port_next, high_port_next};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            control_period_reg <= RST_CONTROL_PERIOD;
            hold_steps_reg     <= RST_HOLD_STEPS;
            high_off_delay_reg <= RST_HIGH_OFF_DELAY;
            low_off_delay_reg  <= RST_LOW_OFF_DELAY;
            pwm_off_duty_reg   <= RST_PWM_OFF_DUTY;
            code_full_rail_reg <= RST_CODE_FULL_RAIL;
            code_band_low_reg  <= RST_CODE_BAND_LOW;
            code_band_high_reg <= RST_CODE_BAND_HIGH;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_CONTROL_PERIOD: control_period_reg <= cfg_wdata;
                REG_HOLD_STEPS:     hold_steps_reg     <= cfg_wdata;
                REG_HIGH_OFF_DELAY: high_off_delay_reg <= cfg_wdata[DELAY_W-1:0];
                REG_LOW_OFF_DELAY:  low_off_delay_reg  <= cfg_wdata[DELAY_W-1:0];
                REG_PWM_OFF_DUTY:   pwm_off_duty_reg   <= cfg_wdata;
                REG_CODE_FULL_RAIL: code_full_rail_reg <= cfg_wdata[VOLTAGE_W-1:0];
                REG_CODE_BAND_LOW:  code_band_low_reg  <= cfg_wdata[VOLTAGE_W-1:0];
                REG_CODE_BAND_HIGH: code_band_high_reg <= cfg_wdata[VOLTAGE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_count_reg   <= '0;
            voltage_req_reg  <= '0;
            duty_req_reg     <= '0;
            voltage_acc_reg  <= '0;
            duty_acc_reg     <= '0;
            hold_count_reg   <= '0;
            high_off_cnt_reg <= '0;
            low_off_cnt_reg  <= '0;
            high_port_reg    <= 1'b0;
            low_port_reg     <= 1'b0;
            pwm_value_reg    <= '0;
            m_tvalid_reg     <= 1'b0;
        end else begin
            tick_count_reg   <= tick_count_next;
            voltage_req_reg  <= voltage_req_next;
            duty_req_reg     <= duty_req_next;
            voltage_acc_reg  <= voltage_acc_next;
            duty_acc_reg     <= duty_acc_next;
            hold_count_reg   <= hold_count_next;
            high_off_cnt_reg <= high_off_cnt_next;
            low_off_cnt_reg  <= low_off_cnt_next;
            high_port_reg    <= high_port_next;
            low_port_reg     <= low_port_next;
            pwm_value_reg    <= pwm_value_next;
            if (s_accept) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTHESIS
    a_tick_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_action == ACT_TICK) |=>
        (tick_count_reg == '0 || tick_count_reg < $past(control_period_reg)))
        else $error("tick counter left at or above the control period");

    a_write_no_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_action != ACT_TICK) |=> !m_tdata[STEP_BIT])
        else $error("control step reported for a non-tick transaction");

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> m_tvalid)
        else $error("accepted transaction produced no result");
`endif

endmodule

// File: sim/tssq_rail_checker.sv
// ----------------------------------------------------------------------------
// tssq_rail_checker
// Watches the input, result and register write ports of the supply rail
// sequencer. It keeps its own copy of the registers and the sequencer state,
// predicts the result of every accepted input transaction, and compares each
// accepted result transaction, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module tssq_rail_checker
    import tssq_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic [ACTION_W-1:0]   s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output int                    mismatch_count,
    output int                    rails_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // Same bit order as the result tdata, high_rail_on in bit 0.
    typedef struct packed {
        logic                 step_done;
        logic [DUTY_W-1:0]    duty_readback;
        logic [VOLTAGE_W-1:0] voltage_readback;
        logic [DUTY_W-1:0]    pwm_compare;
        logic                 low_rail_on;
        logic                 high_rail_on;
    } rail_result_t;

    logic [TICK_W-1:0]    period_cfg;
    logic [TICK_W-1:0]    hold_cfg;
    logic [DELAY_W-1:0]   high_delay_cfg;
    logic [DELAY_W-1:0]   low_delay_cfg;
    logic [DUTY_W-1:0]    off_duty_cfg;
    logic [VOLTAGE_W-1:0] full_code_cfg;
    logic [VOLTAGE_W-1:0] band_lo_cfg;
    logic [VOLTAGE_W-1:0] band_hi_cfg;

    logic [TICK_W-1:0]    tick_cnt;
    logic [VOLTAGE_W-1:0] volt_req;
    logic [DUTY_W-1:0]    duty_req;
    logic [VOLTAGE_W-1:0] volt_acc;
    logic [DUTY_W-1:0]    duty_acc;
    logic [TICK_W-1:0]    hold_cnt;
    logic [DELAY_W-1:0]   high_off_cnt;
    logic [DELAY_W-1:0]   low_off_cnt;
    logic                 high_port;
    logic                 low_port;
    logic [DUTY_W-1:0]    pwm_val;

    rail_result_t rail_expect_q[$];

    function automatic rail_result_t predict_rail_outputs(input logic [ACTION_W-1:0] act,
                                                          input logic [VOLTAGE_W-1:0] volt_in,
                                                          input logic [DUTY_W-1:0] duty_in);
        rail_result_t      r;
        logic [DUTY_W-1:0] duty_now;
        logic              stepped;
        stepped = 1'b0;
        case (act)
            ACT_TICK: begin
                if (tick_cnt < period_cfg) tick_cnt = tick_cnt + TICK_W'(1);
                if (tick_cnt >= period_cfg) begin
                    stepped  = 1'b1;
                    duty_now = duty_req;
                    tick_cnt = '0;
                    if (low_off_cnt != 0) low_off_cnt = low_off_cnt - DELAY_W'(1);
                    if (high_off_cnt != 0) high_off_cnt = high_off_cnt - DELAY_W'(1);
                    // A changed request keeps the old duty until the hold runs out.
                    if (volt_req != volt_acc && hold_cnt != 0) begin
                        hold_cnt = hold_cnt - TICK_W'(1);
                        duty_now = duty_acc;
                    end else begin
                        hold_cnt = hold_cfg;
                        volt_acc = volt_req;
                        duty_acc = duty_now;
                    end
                    if (volt_req == full_code_cfg) begin
                        high_port = 1'b1;
                        if (low_off_cnt == 0) low_port = 1'b0;
                        pwm_val      = off_duty_cfg;
                        high_off_cnt = high_delay_cfg;
                    end else if (volt_req >= band_lo_cfg && volt_req <= band_hi_cfg) begin
                        low_port    = 1'b1;
                        pwm_val     = duty_now;
                        high_port   = (high_off_cnt != 0);
                        low_off_cnt = low_delay_cfg;
                    end else begin
                        high_port = 1'b0;
                        low_port  = 1'b0;
                        pwm_val   = off_duty_cfg;
                        volt_req  = '0;
                    end
                end
            end
            ACT_VOLTAGE: volt_req = volt_in;
            ACT_DUTY:    duty_req = duty_in;
            default: ;
        endcase
        r.high_rail_on     = high_port;
        r.low_rail_on      = low_port;
        r.pwm_compare      = pwm_val;
        r.voltage_readback = volt_req;
        r.duty_readback    = duty_req;
        r.step_done        = stepped;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [DUTY_W-1:0] want,
                               input logic [DUTY_W-1:0] got);
        if (got !== want) begin
            $display("%0t ns: %s expected %0h actual %0h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge aclk) begin : track
        rail_result_t want;
        rail_result_t got;
        if (!aresetn) begin
            period_cfg     = RST_CONTROL_PERIOD;
            hold_cfg       = RST_HOLD_STEPS;
            high_delay_cfg = RST_HIGH_OFF_DELAY;
            low_delay_cfg  = RST_LOW_OFF_DELAY;
            off_duty_cfg   = RST_PWM_OFF_DUTY;
            full_code_cfg  = RST_CODE_FULL_RAIL;
            band_lo_cfg    = RST_CODE_BAND_LOW;
            band_hi_cfg    = RST_CODE_BAND_HIGH;
            tick_cnt       = '0;
            volt_req       = '0;
            duty_req       = '0;
            volt_acc       = '0;
            duty_acc       = '0;
            hold_cnt       = '0;
            high_off_cnt   = '0;
            low_off_cnt    = '0;
            high_port      = 1'b0;
            low_port       = 1'b0;
            pwm_val        = '0;
            rail_expect_q.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_CONTROL_PERIOD: period_cfg     = cfg_wdata;
                    REG_HOLD_STEPS:     hold_cfg       = cfg_wdata;
                    REG_HIGH_OFF_DELAY: high_delay_cfg = cfg_wdata[DELAY_W-1:0];
                    REG_LOW_OFF_DELAY:  low_delay_cfg  = cfg_wdata[DELAY_W-1:0];
                    REG_PWM_OFF_DUTY:   off_duty_cfg   = cfg_wdata;
                    REG_CODE_FULL_RAIL: full_code_cfg  = cfg_wdata[VOLTAGE_W-1:0];
                    REG_CODE_BAND_LOW:  band_lo_cfg    = cfg_wdata[VOLTAGE_W-1:0];
                    REG_CODE_BAND_HIGH: band_hi_cfg    = cfg_wdata[VOLTAGE_W-1:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                got = rail_result_t'(m_tdata[STEP_BIT:0]);
                if (rail_expect_q.size() == 0) begin
                    $display("%0t ns: unexpected result transaction expected none actual %0h",
                             $time, m_tdata);
                    mismatch_count++;
                end else begin
                    want = rail_expect_q.pop_front();
                    check_field("high_rail_on", DUTY_W'(want.high_rail_on),
                                DUTY_W'(got.high_rail_on));
                    check_field("low_rail_on", DUTY_W'(want.low_rail_on),
                                DUTY_W'(got.low_rail_on));
                    check_field("pwm_compare", want.pwm_compare, got.pwm_compare);
                    check_field("voltage_readback", DUTY_W'(want.voltage_readback),
                                DUTY_W'(got.voltage_readback));
                    check_field("duty_readback", want.duty_readback, got.duty_readback);
                    check_field("step_done", DUTY_W'(want.step_done),
                                DUTY_W'(got.step_done));
                end
            end
            if (s_tvalid && s_tready) begin
                rail_expect_q.push_back(predict_rail_outputs(s_tuser,
                                                             s_tdata[VOLTAGE_W-1:0],
                                                             s_tdata[IN_DATA_W-1:VOLTAGE_W]));
            end
        end
        rails_pending = rail_expect_q.size();
    end

endmodule

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the supply rail sequencer. A short directed run
// walks the rail changes, hold and off delays, then randomized transactions
// run under several register settings with varying idle patterns on both
// channels, including one long result stall. A checker module does the
// prediction and comparison.
// ----------------------------------------------------------------------------
module tb_top;
    import tssq_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [ACTION_W-1:0] ACT_SPARE = 2'd3;
    localparam int NUM_SETTINGS = 7;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic [ACTION_W-1:0]   s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    int                    mismatch_count;
    int                    rails_pending;

    int send_idle_pct;
    int rcv_idle_pct;
    bit hold_req;

    logic [VOLTAGE_W-1:0] full_code;
    logic [VOLTAGE_W-1:0] band_lo;
    logic [VOLTAGE_W-1:0] band_hi;

    // Setting 0 is for the directed run, the others for the random phases.
    int unsigned period_tab   [NUM_SETTINGS] = '{2, 1, 3, 0, 65535, 2, 1};
    int unsigned hold_tab     [NUM_SETTINGS] = '{1, 0, 3, 65535, 5, 4, 1};
    int unsigned hi_delay_tab [NUM_SETTINGS] = '{2, 0, 255, 2, 1, 1, 3};
    int unsigned lo_delay_tab [NUM_SETTINGS] = '{1, 0, 255, 3, 1, 2, 0};
    int unsigned off_duty_tab [NUM_SETTINGS] = '{16'h0abc, 0, 16'hffff, 16'h1234,
                                                 16'h5555, 16'h00ff, 16'h8000};
    int unsigned full_tab     [NUM_SETTINGS] = '{24, 24, 8, 255, 30, 0, 255};
    int unsigned band_lo_tab  [NUM_SETTINGS] = '{5, 5, 5, 0, 20, 200, 255};
    int unsigned band_hi_tab  [NUM_SETTINGS] = '{12, 12, 12, 254, 40, 100, 255};
    int unsigned items_tab    [NUM_SETTINGS] = '{0, 90, 90, 90, 40, 90, 90};

    tem_supply_rail_switch_sequencer_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    tssq_rail_checker i_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .mismatch_count (mismatch_count),
        .rails_pending  (rails_pending)
    );

    always begin
        aclk = 1'b1;
        #1;
        aclk = 1'b0;
        #1;
    end

    initial begin
        #2000000;
        $display("Regression FAIL");
        $finish;
    end

    // Result side: random stalls, plus one long hold-off on request.
    initial begin : receiver
        bit hold_served;
        hold_served = 1'b0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req && !hold_served) begin
                hold_served = 1'b1;
                m_tready <= 1'b0;
                repeat (64) @(negedge aclk);
            end
            m_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val[CFG_DATA_W-1:0];
        @(negedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic apply_setting(input int p);
        write_reg(REG_CONTROL_PERIOD, period_tab[p]);
        write_reg(REG_HOLD_STEPS, hold_tab[p]);
        write_reg(REG_HIGH_OFF_DELAY, hi_delay_tab[p]);
        write_reg(REG_LOW_OFF_DELAY, lo_delay_tab[p]);
        write_reg(REG_PWM_OFF_DUTY, off_duty_tab[p]);
        write_reg(REG_CODE_FULL_RAIL, full_tab[p]);
        write_reg(REG_CODE_BAND_LOW, band_lo_tab[p]);
        write_reg(REG_CODE_BAND_HIGH, band_hi_tab[p]);
        full_code = VOLTAGE_W'(full_tab[p]);
        band_lo   = VOLTAGE_W'(band_lo_tab[p]);
        band_hi   = VOLTAGE_W'(band_hi_tab[p]);
    endtask

    // Called at a falling edge; returns at the falling edge after the handshake.
    task automatic send_item(input logic [ACTION_W-1:0] act, input logic [VOLTAGE_W-1:0] volt,
                             input logic [DUTY_W-1:0] duty);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {duty, volt};
        s_tuser  <= act;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic send_ticks(input int n);
        repeat (n) send_item(ACT_TICK, VOLTAGE_W'($urandom_range(0, 255)),
                             DUTY_W'($urandom_range(0, 65535)));
    endtask

    task automatic send_random_item;
        int                   pick;
        logic [VOLTAGE_W-1:0] volt;
        logic [DUTY_W-1:0]    duty;
        pick = $urandom_range(0, 99);
        volt = VOLTAGE_W'($urandom_range(0, 255));
        duty = DUTY_W'($urandom_range(0, 65535));
        if (pick < 55) begin
            send_item(ACT_TICK, volt, duty);
        end else if (pick < 80) begin
            case ($urandom_range(0, 4))
                0: volt = full_code;
                1: volt = band_lo;
                2: volt = band_hi;
                3: volt = VOLTAGE_W'($urandom_range(band_lo, band_hi));
                default: ;
            endcase
            send_item(ACT_VOLTAGE, volt, duty);
        end else if (pick < 97) begin
            send_item(ACT_DUTY, volt, duty);
        end else begin
            send_item(ACT_SPARE, volt, duty);
        end
    endtask

    task automatic wait_drained;
        int guard;
        guard = 0;
        s_tvalid <= 1'b0;
        while (rails_pending != 0 && guard < 20000) begin
            @(negedge aclk);
            guard++;
        end
    endtask

    initial begin
        s_tvalid      <= 1'b0;
        s_tdata       <= '0;
        s_tuser       <= ACT_TICK;
        cfg_we        <= 1'b0;
        cfg_index     <= REG_CONTROL_PERIOD;
        cfg_wdata     <= '0;
        aresetn       <= 1'b0;
        hold_req      = 1'b0;
        send_idle_pct = 14;
        rcv_idle_pct  = 78;
        full_code     = RST_CODE_FULL_RAIL;
        band_lo       = RST_CODE_BAND_LOW;
        band_hi       = RST_CODE_BAND_HIGH;
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset outputs, and the unused action code with every data bit set.
        send_item(ACT_SPARE, 8'hff, 16'hffff);
        send_ticks(1);
        wait_drained();
        apply_setting(0);

        send_item(ACT_DUTY, 8'h00, 16'hffff);
        send_item(ACT_VOLTAGE, 8'd12, 16'h0000);
        send_ticks(2);
        // Full rail while the low port waits out its off delay, old duty held.
        send_item(ACT_VOLTAGE, 8'd24, 16'h0000);
        send_ticks(4);
        // Back to the band bottom while the high port waits out its delay.
        send_item(ACT_VOLTAGE, 8'd5, 16'h0000);
        send_ticks(4);
        // Invalid codes just outside the band and at the top of the code range.
        send_item(ACT_VOLTAGE, 8'd4, 16'h0000);
        send_ticks(2);
        send_item(ACT_VOLTAGE, 8'd13, 16'h0000);
        send_ticks(2);
        send_item(ACT_VOLTAGE, 8'd255, 16'h0000);
        send_item(ACT_DUTY, 8'h00, 16'h0000);
        send_ticks(2);
        send_item(ACT_SPARE, 8'h00, 16'h0000);
        wait_drained();

        for (int p = 1; p < NUM_SETTINGS; p++) begin
            if (p == 3) begin
                send_idle_pct = 78;
                rcv_idle_pct  = 14;
            end else if (p == 5) begin
                send_idle_pct = 0;
                rcv_idle_pct  = 0;
                hold_req      = 1'b1;
            end
            apply_setting(p);
            repeat (items_tab[p]) send_random_item();
            wait_drained();
        end

        repeat (4) @(negedge aclk);
        if (mismatch_count == 0 && rails_pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
